[sv/ptgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgs_pkg
// Shared types and constants for the principal-to-global stress block.
// ----------------------------------------------------------------------------
package ptgs_pkg;

  localparam int NTERM   = 6;
  localparam int ADJ_W   = 33;
  localparam int PROD_W  = 49;
  localparam int SPLIT   = 24;
  localparam int PART_W  = 57;
  localparam int DET_W   = 50;
  localparam int NUM_W   = 83;
  localparam int NMAG_W  = 82;
  localparam int DMAG_W  = 48;
  localparam int QBITS   = 34;
  localparam int QR_W    = QBITS + 1;

  localparam int TERM_I [NTERM] = '{0, 1, 2, 0, 1, 0};
  localparam int TERM_J [NTERM] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic signed [15:0] dir_r0c0;
    logic signed [15:0] dir_r0c1;
    logic signed [15:0] dir_r0c2;
    logic signed [15:0] dir_r1c0;
    logic signed [15:0] dir_r1c1;
    logic signed [15:0] dir_r1c2;
    logic signed [15:0] dir_r2c0;
    logic signed [15:0] dir_r2c1;
    logic signed [15:0] dir_r2c2;
    logic signed [31:0] principal_one;
    logic signed [31:0] principal_two;
    logic signed [31:0] principal_three;
  } ptgs_in_t;

  typedef struct packed {
    logic signed [31:0] stress_xx;
    logic signed [31:0] stress_yy;
    logic signed [31:0] stress_zz;
    logic signed [31:0] stress_xy;
    logic signed [31:0] stress_yz;
    logic signed [31:0] stress_xz;
    logic               singular;
    logic               clipped;
  } ptgs_out_t;

  typedef struct packed {
    logic [NTERM-1:0][NMAG_W-1:0] num;
    logic [DMAG_W-1:0]            den;
    logic [NTERM-1:0]             neg;
    logic                         singular;
  } job_t;

endpackage

[sv/principal_to_global_stress.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// principal_to_global_stress
// Principal stresses and a direction matrix to six Cartesian stress terms.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A six-stage pipeline
// forms the adjugate, determinant and exact numerators; a queue of
// QUEUE_DEPTH jobs feeds six parallel bit-serial dividers that produce one
// quotient bit per cycle. The divider bank takes a new job only once the
// last job's quotient is complete. The result is on result for one cycle
// with done high and cannot be held off. busy rises while QUEUE_DEPTH items
// are between the input and the divider bank.
module principal_to_global_stress #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ptgs_pkg::ptgs_in_t  operand,
  output logic                done,
  output ptgs_pkg::ptgs_out_t result
);
  import ptgs_pkg::*;

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  logic              front_valid;
  job_t              front_job;
  logic              q_pop;
  logic              q_not_empty;
  job_t              q_head;
  logic [PEND_W-1:0] pending;

  assign busy   = (pending == PEND_W'(QUEUE_DEPTH));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (accept && !q_pop) begin
      pending <= pending + 1'b1;
    end else if (q_pop && !accept) begin
      pending <= pending - 1'b1;
    end
  end

  ptgs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_item   (operand),
    .job_valid (front_valid),
    .job       (front_job)
  );

  ptgs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_job),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ptgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job       (q_head),
    .pop       (q_pop),
    .done      (done),
    .result    (result)
  );

endmodule

[sv/ptgs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgs_front
// Six-stage pipeline: adjugate, products, determinant and exact numerators,
// then sign and magnitude split into a division job.
// ----------------------------------------------------------------------------
module ptgs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ptgs_pkg::ptgs_in_t in_item,
  output logic              job_valid,
  output ptgs_pkg::job_t    job
);
  import ptgs_pkg::*;

  logic v0, v1, v2, v3, v4;
  logic signed [15:0]       d0 [3][3];
  logic signed [31:0]       p0 [3];
  logic signed [15:0]       d1 [3][3];
  logic signed [31:0]       p1 [3];
  logic signed [ADJ_W-1:0]  adj1 [3][3];
  logic signed [31:0]       p2 [3];
  logic signed [PROD_W-1:0] dp2 [3];
  logic signed [PROD_W-1:0] tp2 [NTERM][3];
  logic signed [DET_W-1:0]  det3;
  logic signed [PART_W-1:0] mlo3 [NTERM][3];
  logic signed [PART_W-1:0] mhi3 [NTERM][3];
  logic signed [DET_W-1:0]  det4;
  logic signed [NUM_W-1:0]  num4 [NTERM];
  logic signed [NUM_W-1:0]  num_next [NTERM];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      job_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    d0[0][0] <= in_item.dir_r0c0;
    d0[0][1] <= in_item.dir_r0c1;
    d0[0][2] <= in_item.dir_r0c2;
    d0[1][0] <= in_item.dir_r1c0;
    d0[1][1] <= in_item.dir_r1c1;
    d0[1][2] <= in_item.dir_r1c2;
    d0[2][0] <= in_item.dir_r2c0;
    d0[2][1] <= in_item.dir_r2c1;
    d0[2][2] <= in_item.dir_r2c2;
    p0[0] <= in_item.principal_one;
    p0[1] <= in_item.principal_two;
    p0[2] <= in_item.principal_three;
  end

  always_ff @(posedge clk) begin
    d1 <= d0;
    p1 <= p0;
    adj1[0][0] <= ADJ_W'(d0[1][1]) * ADJ_W'(d0[2][2]) - ADJ_W'(d0[1][2]) * ADJ_W'(d0[2][1]);
    adj1[0][1] <= ADJ_W'(d0[0][2]) * ADJ_W'(d0[2][1]) - ADJ_W'(d0[0][1]) * ADJ_W'(d0[2][2]);
    adj1[0][2] <= ADJ_W'(d0[0][1]) * ADJ_W'(d0[1][2]) - ADJ_W'(d0[0][2]) * ADJ_W'(d0[1][1]);
    adj1[1][0] <= ADJ_W'(d0[1][2]) * ADJ_W'(d0[2][0]) - ADJ_W'(d0[1][0]) * ADJ_W'(d0[2][2]);
    adj1[1][1] <= ADJ_W'(d0[0][0]) * ADJ_W'(d0[2][2]) - ADJ_W'(d0[0][2]) * ADJ_W'(d0[2][0]);
    adj1[1][2] <= ADJ_W'(d0[0][2]) * ADJ_W'(d0[1][0]) - ADJ_W'(d0[0][0]) * ADJ_W'(d0[1][2]);
    adj1[2][0] <= ADJ_W'(d0[1][0]) * ADJ_W'(d0[2][1]) - ADJ_W'(d0[1][1]) * ADJ_W'(d0[2][0]);
    adj1[2][1] <= ADJ_W'(d0[0][1]) * ADJ_W'(d0[2][0]) - ADJ_W'(d0[0][0]) * ADJ_W'(d0[2][1]);
    adj1[2][2] <= ADJ_W'(d0[0][0]) * ADJ_W'(d0[1][1]) - ADJ_W'(d0[0][1]) * ADJ_W'(d0[1][0]);
  end

  always_ff @(posedge clk) begin
    p2 <= p1;
    for (int k = 0; k < 3; k++) begin
      dp2[k] <= PROD_W'(d1[0][k]) * PROD_W'(adj1[k][0]);
    end
    for (int t = 0; t < NTERM; t++) begin
      for (int k = 0; k < 3; k++) begin
        tp2[t][k] <= PROD_W'(adj1[TERM_I[t]][k]) * PROD_W'(d1[k][TERM_J[t]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    det3 <= DET_W'(dp2[0]) + DET_W'(dp2[1]) + DET_W'(dp2[2]);
    for (int t = 0; t < NTERM; t++) begin
      for (int k = 0; k < 3; k++) begin
        mlo3[t][k] <= PART_W'($signed({1'b0, tp2[t][k][SPLIT-1:0]})) * PART_W'(p2[k]);
        mhi3[t][k] <= PART_W'($signed(tp2[t][k][PROD_W-1:SPLIT])) * PART_W'(p2[k]);
      end
    end
  end

  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      num_next[t] = '0;
      for (int k = 0; k < 3; k++) begin
        num_next[t] = num_next[t] + (NUM_W'(mhi3[t][k]) <<< SPLIT) + NUM_W'(mlo3[t][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    det4 <= det3;
    num4 <= num_next;
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < NTERM; t++) begin
      job.num[t] <= num4[t][NUM_W-1] ? NMAG_W'(-num4[t]) : NMAG_W'(num4[t]);
      job.neg[t] <= num4[t][NUM_W-1] ^ det4[DET_W-1];
    end
    job.den <= det4[DET_W-1] ? DMAG_W'(-det4) : DMAG_W'(det4);
    job.singular <= (det4 == '0);
  end

endmodule

[sv/ptgs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgs_fifo
// Short job queue between the numerator pipeline and the divider bank.
// ----------------------------------------------------------------------------
module ptgs_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ptgs_pkg::job_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output ptgs_pkg::job_t head
);
  import ptgs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

endmodule

[sv/ptgs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgs_back
// Six radix-2 divider lanes sharing one shifted divisor; rounds, saturates
// and registers the result.
// ----------------------------------------------------------------------------
module ptgs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  ptgs_pkg::job_t      job,
  output logic                pop,
  output logic                done,
  output ptgs_pkg::ptgs_out_t result
);
  import ptgs_pkg::*;

  localparam int CNT_W = $clog2(QBITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  logic [NMAG_W-1:0]  rem [NTERM];
  logic [QBITS-1:0]   quo [NTERM];
  logic [NMAG_W-1:0]  dsh;
  logic [DMAG_W-1:0]  den;
  logic [NTERM-1:0]   neg;
  logic [NTERM-1:0]   over;
  logic               sing;
  logic               can_load;
  logic [QR_W-1:0]    qr [NTERM];
  logic [QR_W-1:0]    lim [NTERM];
  logic [QR_W-1:0]    mag [NTERM];
  logic [NTERM-1:0]   sat;
  logic [31:0]        val [NTERM];

  assign can_load = (state == ST_IDLE) || (state == ST_FIN);
  assign pop      = can_load && job_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (job_valid) state_next = ST_RUN;
      ST_RUN:  if (cnt == '0) state_next = ST_FIN;
      ST_FIN:  state_next = job_valid ? ST_RUN : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FIN);
      if (pop) begin
        cnt <= CNT_W'(QBITS - 1);
      end else if (state == ST_RUN) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dsh  <= NMAG_W'(job.den) << (QBITS - 1);
      den  <= job.den;
      neg  <= job.neg;
      sing <= job.singular;
      for (int t = 0; t < NTERM; t++) begin
        rem[t]  <= job.num[t];
        quo[t]  <= '0;
        over[t] <= (job.num[t][NMAG_W-1:QBITS] >= (NMAG_W - QBITS)'(job.den));
      end
    end else if (state == ST_RUN) begin
      dsh <= dsh >> 1;
      for (int t = 0; t < NTERM; t++) begin
        if (rem[t] >= dsh) begin
          rem[t] <= rem[t] - dsh;
          quo[t] <= {quo[t][QBITS-2:0], 1'b1};
        end else begin
          quo[t] <= {quo[t][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      qr[t]  = QR_W'(quo[t])
             + QR_W'(((NMAG_W + 1)'(rem[t]) << 1) >= (NMAG_W + 1)'(den));
      lim[t] = neg[t] ? QR_W'(64'h8000_0000) : QR_W'(64'h7FFF_FFFF);
      sat[t] = over[t] || (qr[t] > lim[t]);
      mag[t] = sat[t] ? lim[t] : qr[t];
      val[t] = neg[t] ? (~mag[t][31:0] + 32'd1) : mag[t][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      result.stress_xx <= sing ? '0 : val[0];
      result.stress_yy <= sing ? '0 : val[1];
      result.stress_zz <= sing ? '0 : val[2];
      result.stress_xy <= sing ? '0 : val[3];
      result.stress_yz <= sing ? '0 : val[4];
      result.stress_xz <= sing ? '0 : val[5];
      result.singular  <= sing;
      result.clipped   <= !sing && (sat != '0);
    end
  end

endmodule

[verif/principal_to_global_stress_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// principal_to_global_stress_test
// Self-checking bench for the principal-to-global stress block. Each transfer
// is predicted with exact wide integer arithmetic: adjugate, determinant,
// rounded and saturated quotients. Results are checked in order against the
// predicted tensors. The stimulus covers directed corner cases, then random
// direction matrices and stresses, mostly with random idle gaps.
// ----------------------------------------------------------------------------
module principal_to_global_stress_test;
  import ptgs_pkg::*;

  localparam int N_RANDOM    = 1930;
  localparam int STALL_LIMIT = 4000;

  class tensor_board;
    ptgs_out_t pending[$];
    int        n_bad;

    function ptgs_out_t predict(ptgs_in_t x);
      logic signed [127:0] d[3][3];
      logic signed [127:0] a[3][3];
      logic signed [127:0] p[3];
      logic signed [127:0] det, num;
      logic        [127:0] nm, dm, q, r, lim;
      logic signed [31:0]  term[NTERM];
      ptgs_out_t y;
      logic neg, clip;
      int i, j;
      d[0][0] = x.dir_r0c0; d[0][1] = x.dir_r0c1; d[0][2] = x.dir_r0c2;
      d[1][0] = x.dir_r1c0; d[1][1] = x.dir_r1c1; d[1][2] = x.dir_r1c2;
      d[2][0] = x.dir_r2c0; d[2][1] = x.dir_r2c1; d[2][2] = x.dir_r2c2;
      p[0] = x.principal_one; p[1] = x.principal_two; p[2] = x.principal_three;
      a[0][0] = d[1][1] * d[2][2] - d[1][2] * d[2][1];
      a[0][1] = d[0][2] * d[2][1] - d[0][1] * d[2][2];
      a[0][2] = d[0][1] * d[1][2] - d[0][2] * d[1][1];
      a[1][0] = d[1][2] * d[2][0] - d[1][0] * d[2][2];
      a[1][1] = d[0][0] * d[2][2] - d[0][2] * d[2][0];
      a[1][2] = d[0][2] * d[1][0] - d[0][0] * d[1][2];
      a[2][0] = d[1][0] * d[2][1] - d[1][1] * d[2][0];
      a[2][1] = d[0][1] * d[2][0] - d[0][0] * d[2][1];
      a[2][2] = d[0][0] * d[1][1] - d[0][1] * d[1][0];
      det = d[0][0] * a[0][0] + d[0][1] * a[1][0] + d[0][2] * a[2][0];
      y = '0;
      if (det == 0) begin
        y.singular = 1'b1;
        return y;
      end
      clip = 1'b0;
      dm = (det < 0) ? -det : det;
      for (int t = 0; t < NTERM; t++) begin
        i = TERM_I[t];
        j = TERM_J[t];
        num = a[i][0] * d[0][j] * p[0] + a[i][1] * d[1][j] * p[1]
            + a[i][2] * d[2][j] * p[2];
        neg = (num < 0) != (det < 0);
        nm = (num < 0) ? -num : num;
        q = nm / dm;
        r = nm % dm;
        if (r >= dm - r) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
          clip = 1'b1;
          q = lim;
        end
        term[t] = neg ? -q[31:0] : q[31:0];
      end
      y.stress_xx = term[0];
      y.stress_yy = term[1];
      y.stress_zz = term[2];
      y.stress_xy = term[3];
      y.stress_yz = term[4];
      y.stress_xz = term[5];
      y.clipped   = clip;
      return y;
    endfunction

    function void note_transfer(ptgs_in_t x);
      pending.push_back(predict(x));
    endfunction

    function void check_tensor(ptgs_out_t y);
      ptgs_out_t e;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", y);
        return;
      end
      e = pending.pop_front();
      if (y !== e) begin
        n_bad++;
        if (n_bad <= 10)
          $display("tensor mismatch (exp/act): xx %0d/%0d yy %0d/%0d zz %0d/%0d",
                   e.stress_xx, y.stress_xx, e.stress_yy, y.stress_yy,
                   e.stress_zz, y.stress_zz,
                   " xy %0d/%0d yz %0d/%0d xz %0d/%0d",
                   e.stress_xy, y.stress_xy, e.stress_yz, y.stress_yz,
                   e.stress_xz, y.stress_xz,
                   " sing %b/%b clip %b/%b",
                   e.singular, y.singular, e.clipped, y.clipped);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  ptgs_in_t  operand;
  logic      done;
  ptgs_out_t result;

  tensor_board board;
  int          stall_cycles = 0;

  principal_to_global_stress dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_transfer(operand);
      if (done) board.check_tensor(result);
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic ptgs_in_t make_item(logic [15:0] m[9], logic [31:0] p1,
                                         logic [31:0] p2, logic [31:0] p3);
    ptgs_in_t x;
    x.dir_r0c0 = m[0]; x.dir_r0c1 = m[1]; x.dir_r0c2 = m[2];
    x.dir_r1c0 = m[3]; x.dir_r1c1 = m[4]; x.dir_r1c2 = m[5];
    x.dir_r2c0 = m[6]; x.dir_r2c1 = m[7]; x.dir_r2c2 = m[8];
    x.principal_one = p1; x.principal_two = p2; x.principal_three = p3;
    return x;
  endfunction

  task automatic send(ptgs_in_t x, bit gaps);
    while (gaps && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    operand <= x;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] rand_stress();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2000) - 1000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic random_item(bit gaps);
    logic [15:0] m[9];
    int mode, sh;
    mode = $urandom_range(0, 3);
    sh = $urandom_range(0, 13);
    for (int k = 0; k < 9; k++) begin
      case (mode)
        0: m[k] = 16'($urandom);
        1: m[k] = 16'($signed($urandom_range(0, 6)) - 3) << sh;
        2: m[k] = (k % 4 == 0) ? 16'(16384 + $urandom_range(0, 64) - 32)
                               : 16'($urandom_range(0, 64) - 32);
        default: m[k] = 16'($signed($urandom_range(0, 2)) - 1);
      endcase
    end
    send(make_item(m, rand_stress(), rand_stress(), rand_stress()), gaps);
  endtask

  initial begin
    logic [15:0] m[9];
    board = new();
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    m = '{16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384};
    send(make_item(m, 32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_FFFF), 1'b0);
    send(make_item(m, 32'h8000_0000, 32'h0, 32'h1), 1'b0);
    m = '{default: 16'd0};
    send(make_item(m, 32'h1234_5678, 32'h1, 32'h2), 1'b0);
    m = '{default: 16'h8000};
    send(make_item(m, 32'h1, 32'h1, 32'h1), 1'b0);
    m = '{16'h7FFF, 16'h8000, 16'h0, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF};
    send(make_item(m, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0);
    m = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
          16'h7FFF, 16'h8000};
    send(make_item(m, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 1'b0);
    m = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1};
    send(make_item(m, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3), 1'b0);
    m = '{16'd2, 16'd1, 16'd0, 16'd0, 16'd2, 16'd1, 16'd1, 16'd0, 16'd2};
    send(make_item(m, 32'd1, 32'd2, 32'd3), 1'b0);
    send(make_item(m, 32'hFFFF_FFFF, 32'd0, 32'd5), 1'b0);
    m = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd9};
    send(make_item(m, 32'd7, 32'd7, 32'd7), 1'b0);
    m = '{16'd11585, 16'hD2BF, 16'd0, 16'd11585, 16'd11585, 16'd0, 16'd0, 16'd0, 16'd16384};
    send(make_item(m, 32'h0064_0000, 32'hFF9C_0000, 32'h0), 1'b0);
    m = '{16'd3, 16'd0, 16'd0, 16'd0, 16'd3, 16'd1, 16'd0, 16'd1, 16'd3};
    send(make_item(m, 32'd1, 32'd2, 32'hFFFF_FFFD), 1'b0);

    for (int n = 0; n < N_RANDOM; n++)
      random_item(!(n >= 800 && n < 1100));
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ptgs_pkg.sv
sv/ptgs_front.sv
sv/ptgs_fifo.sv
sv/ptgs_back.sv
sv/principal_to_global_stress.sv
verif/principal_to_global_stress_test.sv
